/* rtl/rdc_pkg.sv */
// Package for the radix digit converter: result type, constants and the ASCII mapping.
package rdc_pkg;

   localparam int RADIX_BITS    = 5;
   localparam int DIGIT_BITS    = 4;
   localparam int CHAR_BITS     = 7;

   localparam logic [RADIX_BITS-1:0] RADIX_MIN     = 5'd2;
   localparam logic [RADIX_BITS-1:0] RADIX_MAX     = 5'd16;
   localparam logic [CHAR_BITS-1:0]  ASCII_ZERO    = 7'd48;
   localparam logic [CHAR_BITS-1:0]  ALPHA_OFFSET  = 7'd55;
   localparam logic [DIGIT_BITS-1:0] DECIMAL_LIMIT = 4'd10;
   localparam logic [CHAR_BITS-1:0]  ERROR_CHAR    = 7'd0;

   typedef struct packed {
      logic [CHAR_BITS-1:0] digit_char;
      logic                 last;
      logic                 error;
   } rsp_type;

   function automatic logic [CHAR_BITS-1:0] to_ascii(input logic [DIGIT_BITS-1:0] digit);
      logic [CHAR_BITS-1:0] wide;
      wide = {{(CHAR_BITS-DIGIT_BITS){1'b0}}, digit};
      if (digit < DECIMAL_LIMIT) begin
         return ASCII_ZERO + wide;
      end
      return ALPHA_OFFSET + wide;
   endfunction

endpackage

/* rtl/rdc_front.sv */
// Front end: accepts items, flags a bad radix and holds them in a two-entry job queue.
module rdc_front #(
   parameter int VALUE_BITS = 31
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_push,
   output logic                           req_full,
   input  logic [VALUE_BITS-1:0]          req_value,
   input  logic [rdc_pkg::RADIX_BITS-1:0] req_radix,
   output logic                           job_valid,
   input  logic                           job_take,
   output logic [VALUE_BITS-1:0]          job_value,
   output logic [rdc_pkg::RADIX_BITS-1:0] job_radix,
   output logic                           job_error
);

   logic [VALUE_BITS-1:0]          value_ff [2];
   logic [rdc_pkg::RADIX_BITS-1:0] radix_ff [2];
   logic                           error_ff [2];
   logic                           wr_ptr_ff, wr_ptr_in;
   logic                           rd_ptr_ff, rd_ptr_in;
   logic [1:0]                     count_ff, count_in;
   logic                           push_ok;
   logic                           take_ok;
   logic                           bad_radix;

   assign req_full  = (count_ff == 2'd2);
   assign job_valid = (count_ff != 2'd0);
   assign push_ok   = req_push && !req_full;
   assign take_ok   = job_take && job_valid;

   // A radix outside two to sixteen turns into a single error result downstream.
   assign bad_radix = (req_radix < rdc_pkg::RADIX_MIN) || (req_radix > rdc_pkg::RADIX_MAX);

   assign job_value = value_ff[rd_ptr_ff];
   assign job_radix = radix_ff[rd_ptr_ff];
   assign job_error = error_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push_ok ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = take_ok ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok && !take_ok) begin
         count_in = count_ff + 2'd1;
      end else if (take_ok && !push_ok) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         value_ff[wr_ptr_ff] <= req_value;
         radix_ff[wr_ptr_ff] <= req_radix;
         error_ff[wr_ptr_ff] <= bad_radix;
      end
   end

endmodule

/* rtl/rdc_back.sv */
// Back end: finds the highest power of the radix, then peels off one digit per pass.
module rdc_back #(
   parameter int VALUE_BITS = 31
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           job_valid,
   output logic                           job_take,
   input  logic [VALUE_BITS-1:0]          job_value,
   input  logic [rdc_pkg::RADIX_BITS-1:0] job_radix,
   input  logic                           job_error,
   output logic                           out_push,
   output rdc_pkg::rsp_type               out_item,
   input  logic                           out_full
);

   localparam int IDX_BITS  = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
   localparam int PROD_BITS = VALUE_BITS + rdc_pkg::RADIX_BITS;
   localparam int SHIFT_BITS = VALUE_BITS + 3;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SEARCH = 3'd1;
   localparam logic [2:0] S_FETCH  = 3'd2;
   localparam logic [2:0] S_DIVIDE = 3'd3;
   localparam logic [2:0] S_EMIT   = 3'd4;

   logic [2:0]                           state_ff, state_in;
   logic [VALUE_BITS-1:0]                rem_ff, rem_in;
   logic [VALUE_BITS-1:0]                place_ff, place_in;
   logic [rdc_pkg::RADIX_BITS-1:0]       radix_ff, radix_in;
   logic [IDX_BITS-1:0]                  idx_ff, idx_in;
   logic [1:0]                           bit_ff, bit_in;
   logic [rdc_pkg::DIGIT_BITS-1:0]       digit_ff, digit_in;
   logic                                 error_ff, error_in;

   // Table of powers of the radix, filled during the search and read back from the top.
   logic [VALUE_BITS-1:0]                pow_mem [VALUE_BITS];
   logic [VALUE_BITS-1:0]                pow_q;

   logic [PROD_BITS-1:0]                 prod;
   logic [SHIFT_BITS-1:0]                shifted;
   logic [SHIFT_BITS-1:0]                rem_ext;
   logic                                 fits;

   assign prod    = {{rdc_pkg::RADIX_BITS{1'b0}}, place_ff}
                  * {{VALUE_BITS{1'b0}}, radix_ff};
   assign rem_ext = {3'b000, rem_ff};
   assign shifted = {3'b000, pow_q} << bit_ff;
   assign fits    = (rem_ext >= shifted);

   assign job_take = (state_ff == S_IDLE) && job_valid;
   assign out_push = (state_ff == S_EMIT) && !out_full;

   always_comb begin
      out_item = '0;
      if (error_ff) begin
         out_item.digit_char = rdc_pkg::ERROR_CHAR;
         out_item.last       = 1'b1;
         out_item.error      = 1'b1;
      end else begin
         out_item.digit_char = rdc_pkg::to_ascii(digit_ff);
         out_item.last       = (idx_ff == '0);
         out_item.error      = 1'b0;
      end
   end

   always_comb begin
      state_in = state_ff;
      rem_in   = rem_ff;
      place_in = place_ff;
      radix_in = radix_ff;
      idx_in   = idx_ff;
      bit_in   = bit_ff;
      digit_in = digit_ff;
      error_in = error_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (job_valid) begin
               rem_in   = job_value;
               radix_in = job_radix;
               error_in = job_error;
               place_in = {{(VALUE_BITS-1){1'b0}}, 1'b1};
               idx_in   = '0;
               state_in = job_error ? S_EMIT : S_SEARCH;
            end
         end
         S_SEARCH: begin
            // place * radix <= remaining is the exact form of place <= remaining / radix.
            if (prod <= {{rdc_pkg::RADIX_BITS{1'b0}}, rem_ff}) begin
               place_in = prod[VALUE_BITS-1:0];
               idx_in   = idx_ff + IDX_BITS'(1);
            end else begin
               state_in = S_FETCH;
            end
         end
         S_FETCH: begin
            bit_in   = 2'd3;
            digit_in = '0;
            state_in = S_DIVIDE;
         end
         S_DIVIDE: begin
            // Restoring division: the digit is below sixteen, so four steps suffice.
            if (fits) begin
               rem_in           = rem_ff - shifted[VALUE_BITS-1:0];
               digit_in[bit_ff] = 1'b1;
            end
            bit_in = bit_ff - 2'd1;
            if (bit_ff == 2'd0) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (!out_full) begin
               if (error_ff || (idx_ff == '0)) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in   = idx_ff - IDX_BITS'(1);
                  state_in = S_FETCH;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      place_ff <= place_in;
      radix_ff <= radix_in;
      idx_ff   <= idx_in;
      bit_ff   <= bit_in;
      digit_ff <= digit_in;
      error_ff <= error_in;
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_SEARCH) begin
         pow_mem[idx_ff] <= place_ff;
      end
      pow_q <= pow_mem[idx_ff];
   end

endmodule

/* rtl/rdc_out_fifo.sv */
// Result queue: four entries between the digit engine and the result ports.
module rdc_out_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  rdc_pkg::rsp_type item,
   output logic             full,
   output logic             empty,
   input  logic             pop,
   output rdc_pkg::rsp_type head
);

   rdc_pkg::rsp_type entry_ff [4];
   logic [1:0]       wr_ptr_ff, wr_ptr_in;
   logic [1:0]       rd_ptr_ff, rd_ptr_in;
   logic [2:0]       count_ff, count_in;
   logic             push_ok;
   logic             pop_ok;

   assign full    = (count_ff == 3'd4);
   assign empty   = (count_ff == 3'd0);
   assign push_ok = push && !full;
   assign pop_ok  = pop && !empty;
   assign head    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push_ok ? wr_ptr_ff + 2'd1 : wr_ptr_ff;
      rd_ptr_in = pop_ok ? rd_ptr_ff + 2'd1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok && !pop_ok) begin
         count_in = count_ff + 3'd1;
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 2'd0;
         rd_ptr_ff <= 2'd0;
         count_ff  <= 3'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         entry_ff[wr_ptr_ff] <= item;
      end
   end

endmodule

/* rtl/radix_digit_converter.sv */
// The engine takes an item and searches its powers, then handles each digit with a table read,
// four restoring-division steps and a result write; a bad radix goes straight to its error result.
// It works on one item at a time and takes the next from the front end only once the last digit
// of the current one has gone into the result queue, and a full result queue holds it back.
// Reset: synchronous, active high; it empties both queues and idles the engine, no sweep.
// Top level of the radix digit converter.
module radix_digit_converter #(
   parameter int VALUE_BITS = 31
) (
   input  logic                           clock,
   input  logic                           reset,
   // Input channel: an item enters when push is high and full is low.
   input  logic                           req_push,
   output logic                           req_full,
   input  logic [VALUE_BITS-1:0]          req_value,
   input  logic [rdc_pkg::RADIX_BITS-1:0] req_radix,
   // Result channel: the oldest digit is shown while empty is low.
   output logic                           rsp_empty,
   input  logic                           rsp_pop,
   output logic [rdc_pkg::CHAR_BITS-1:0]  rsp_digit_char,
   output logic                           rsp_last,
   output logic                           rsp_error
);

   // The front end checks the radix and queues the item so that new items
   // can be taken while the engine is still busy with an earlier one.
   logic                           job_valid;
   logic                           job_take;
   logic [VALUE_BITS-1:0]          job_value;
   logic [rdc_pkg::RADIX_BITS-1:0] job_radix;
   logic                           job_error;

   // The engine writes finished digits into the result queue, which lets it
   // keep working while the consumer holds off.
   logic                           out_push;
   logic                           out_full;
   rdc_pkg::rsp_type               out_item;
   rdc_pkg::rsp_type               out_head;

   rdc_front #(
      .VALUE_BITS (VALUE_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_value (req_value),
      .req_radix (req_radix),
      .job_valid (job_valid),
      .job_take  (job_take),
      .job_value (job_value),
      .job_radix (job_radix),
      .job_error (job_error)
   );

   // The engine first multiplies its way up to the highest power of the radix
   // not above the value, storing each power, then walks back down the table,
   // taking one digit per power with a four-step restoring division.
   rdc_back #(
      .VALUE_BITS (VALUE_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .job_take  (job_take),
      .job_value (job_value),
      .job_radix (job_radix),
      .job_error (job_error),
      .out_push  (out_push),
      .out_item  (out_item),
      .out_full  (out_full)
   );

   rdc_out_fifo u_out_fifo (
      .clock (clock),
      .reset (reset),
      .push  (out_push),
      .item  (out_item),
      .full  (out_full),
      .empty (rsp_empty),
      .pop   (rsp_pop),
      .head  (out_head)
   );

   assign rsp_digit_char = out_head.digit_char;
   assign rsp_last       = out_head.last;
   assign rsp_error      = out_head.error;

endmodule

/* rtl/rdc_checker.sv */
// Port-level checks for the radix digit converter and the bind that attaches them.
module rdc_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_full,
   input logic                          rsp_empty,
   input logic                          rsp_pop,
   input logic [rdc_pkg::CHAR_BITS-1:0] rsp_digit_char,
   input logic                          rsp_last,
   input logic                          rsp_error
);

   // Reset leaves no result waiting and room for a new item.
   a_reset_clears: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("results or a full input survived reset");

   // An error result is a lone item with a zero character.
   a_error_shape: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_error) |-> (rsp_last && (rsp_digit_char == rdc_pkg::ERROR_CHAR)))
      else $error("error result is not a single zero item");

   // A normal result is always an uppercase hex digit character.
   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_error) |->
         (((rsp_digit_char >= 7'd48) && (rsp_digit_char <= 7'd57)) ||
          ((rsp_digit_char >= 7'd65) && (rsp_digit_char <= 7'd70))))
      else $error("digit character out of range");

   // A waiting result that is not taken stays put.
   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=>
         (!rsp_empty && $stable(rsp_digit_char) && $stable(rsp_last) && $stable(rsp_error)))
      else $error("waiting result changed before it was taken");

endmodule

bind radix_digit_converter rdc_checker u_rdc_checker (
   .clock          (clock),
   .reset          (reset),
   .req_full       (req_full),
   .rsp_empty      (rsp_empty),
   .rsp_pop        (rsp_pop),
   .rsp_digit_char (rsp_digit_char),
   .rsp_last       (rsp_last),
   .rsp_error      (rsp_error)
);

/* tb/radix_digit_converter_tb.sv */
// Self-checking testbench for the radix digit converter: directed table, random items, digit checks.
module radix_digit_converter_tb;

   localparam int VALUE_BITS = 31;

   // The slowest correct item is a full 31-bit value in radix 2: 31 digits, each of which
   // may sit out a stall at the output.
   localparam int CYCLE_LIMIT = 1000000;

   // After the last expected digit has been taken, this wait lets any stray results show up.
   localparam int DRAIN_CYCLES = 300;

   localparam int RANDOM_ITEMS = 360;
   localparam int QUIET_ITEMS  = 40;

   logic                           clock;
   logic                           reset;
   logic                           req_push;
   logic                           req_full;
   logic [VALUE_BITS-1:0]          req_value;
   logic [rdc_pkg::RADIX_BITS-1:0] req_radix;
   logic                           rsp_empty;
   logic                           rsp_pop;
   logic [rdc_pkg::CHAR_BITS-1:0]  rsp_digit_char;
   logic                           rsp_last;
   logic                           rsp_error;

   // Digits that the converter still owes, oldest first.
   rdc_pkg::rsp_type pending_digits[$];

   int  mismatch_count;
   int  cycle_count;
   // When set, neither side idles; the last part of the run is kept free of gaps.
   bit  quiet;

   radix_digit_converter #(
      .VALUE_BITS(VALUE_BITS)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_value      (req_value),
      .req_radix      (req_radix),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_digit_char (rsp_digit_char),
      .rsp_last       (rsp_last),
      .rsp_error      (rsp_error)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // A row of the directed table either carries its digits typed in, names a rejected
   // radix, or is left to the digit predictor below.
   typedef enum {
      ROW_PREDICTED,
      ROW_DIGITS,
      ROW_BAD_RADIX
   } row_kind_type;

   typedef struct {
      logic [VALUE_BITS-1:0]          value;
      logic [rdc_pkg::RADIX_BITS-1:0] radix;
      row_kind_type                   kind;
      string                          digits;
   } directed_row_type;

   localparam logic [VALUE_BITS-1:0] VALUE_MAX = {VALUE_BITS{1'b1}};

   directed_row_type directed_rows[] = '{
      // Zero gives a single '0', right after reset and in the smallest and largest radix.
      '{31'd0,         5'd10, ROW_DIGITS,    "0"},
      '{31'd0,         5'd2,  ROW_DIGITS,    "0"},
      '{31'd0,         5'd16, ROW_DIGITS,    "0"},
      // The largest value in the three common radixes, then one in radix two and sixteen.
      '{VALUE_MAX,     5'd2,  ROW_DIGITS,    "1111111111111111111111111111111"},
      '{VALUE_MAX,     5'd16, ROW_DIGITS,    "7FFFFFFF"},
      '{VALUE_MAX,     5'd10, ROW_DIGITS,    "2147483647"},
      '{31'd1,         5'd2,  ROW_DIGITS,    "1"},
      '{31'd1,         5'd16, ROW_DIGITS,    "1"},
      // The last single hex digit, the first two-digit value, then larger hex values.
      '{31'd15,        5'd16, ROW_DIGITS,    "F"},
      '{31'd16,        5'd16, ROW_DIGITS,    "10"},
      '{31'd255,       5'd16, ROW_DIGITS,    "FF"},
      '{31'hABCDEF,    5'd16, ROW_DIGITS,    "ABCDEF"},
      // Radixes below two and above sixteen are rejected, whatever the value.
      '{31'd5,         5'd0,  ROW_BAD_RADIX, ""},
      '{VALUE_MAX,     5'd1,  ROW_BAD_RADIX, ""},
      '{31'd12345,     5'd17, ROW_BAD_RADIX, ""},
      '{31'd0,         5'd31, ROW_BAD_RADIX, ""},
      // Alternating bit patterns, values on or next to a power of the radix, and other large values.
      '{31'h2AAAAAAA,  5'd2,  ROW_PREDICTED, ""},
      '{31'h55555555,  5'd4,  ROW_PREDICTED, ""},
      '{31'd9,         5'd3,  ROW_PREDICTED, ""},
      '{31'd80,        5'd3,  ROW_PREDICTED, ""},
      '{VALUE_MAX,     5'd3,  ROW_PREDICTED, ""},
      '{31'd1000000,   5'd7,  ROW_PREDICTED, ""},
      '{31'd99,        5'd10, ROW_PREDICTED, ""},
      '{31'd6560,      5'd9,  ROW_PREDICTED, ""},
      '{31'h7FFFFFFE,  5'd15, ROW_PREDICTED, ""}
   };

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("MISMATCH at cycle %0d: %s got %0d, expected %0d", cycle_count, what, got, want);
      mismatch_count++;
   endtask

   // Works out the digits of one conversion: the highest power of the radix not above the
   // value is found first, then the value is divided by falling powers down to one.
   function automatic void predict_digits(input logic [VALUE_BITS-1:0] value,
                                          input logic [rdc_pkg::RADIX_BITS-1:0] radix);
      longint unsigned  rest;
      longint unsigned  place;
      longint unsigned  base;
      longint unsigned  digit;
      rdc_pkg::rsp_type entry;
      int               count;
      if (radix < rdc_pkg::RADIX_MIN || radix > rdc_pkg::RADIX_MAX) begin
         entry.digit_char = rdc_pkg::ERROR_CHAR;
         entry.last       = 1'b1;
         entry.error      = 1'b1;
         pending_digits.push_back(entry);
         return;
      end
      base  = radix;
      rest  = value;
      place = 1;
      while (place <= rest / base) begin
         place = place * base;
      end
      count = 0;
      forever begin
         digit = rest / place;
         rest  = rest % place;
         if (digit < rdc_pkg::DECIMAL_LIMIT) begin
            entry.digit_char = rdc_pkg::ASCII_ZERO + rdc_pkg::CHAR_BITS'(digit);
         end else begin
            entry.digit_char = rdc_pkg::ALPHA_OFFSET + rdc_pkg::CHAR_BITS'(digit);
         end
         entry.last  = (place == 1);
         entry.error = 1'b0;
         pending_digits.push_back(entry);
         count++;
         if (place == 1 || count >= VALUE_BITS) begin
            break;
         end
         place = place / base;
      end
   endfunction

   // Queues the digits of a directed row that were typed in as text.
   function automatic void queue_typed_digits(input string text);
      rdc_pkg::rsp_type entry;
      for (int k = 0; k < text.len(); k++) begin
         entry.digit_char = rdc_pkg::CHAR_BITS'(text[k]);
         entry.last       = (k == text.len() - 1);
         entry.error      = 1'b0;
         pending_digits.push_back(entry);
      end
   endfunction

   // Mostly valid radixes, with a share of rejected ones spread over the whole field.
   function automatic logic [rdc_pkg::RADIX_BITS-1:0] random_radix();
      if ($urandom_range(0, 9) == 0) begin
         return rdc_pkg::RADIX_BITS'($urandom_range(0, 31));
      end
      return rdc_pkg::RADIX_BITS'($urandom_range(rdc_pkg::RADIX_MIN, rdc_pkg::RADIX_MAX));
   endfunction

   // Values of every size: tiny ones, random widths, full 31-bit patterns, and values on
   // either side of a power of the radix, where the power search is most likely to slip.
   function automatic logic [VALUE_BITS-1:0] random_value(
         input logic [rdc_pkg::RADIX_BITS-1:0] radix);
      longint unsigned power;
      int              width;
      int              steps;
      int              mode;
      mode = $urandom_range(0, 3);
      if (mode == 2 && (radix < rdc_pkg::RADIX_MIN || radix > rdc_pkg::RADIX_MAX)) begin
         mode = 3;
      end
      case (mode)
         0: begin
            return VALUE_BITS'($urandom_range(0, 20));
         end
         1: begin
            width = $urandom_range(1, VALUE_BITS);
            return VALUE_BITS'($urandom) & VALUE_BITS'((64'd1 << width) - 1);
         end
         2: begin
            power = 1;
            steps = $urandom_range(0, VALUE_BITS - 1);
            repeat (steps) begin
               if (power * radix <= VALUE_MAX) begin
                  power = power * radix;
               end
            end
            power = power + $urandom_range(0, 2) - 1;
            return VALUE_BITS'(power);
         end
         default: begin
            return VALUE_BITS'($urandom);
         end
      endcase
   endfunction

   // Holds push low for a random burst now and then, unless the run is in its quiet part.
   task automatic sender_pause();
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_push  <= 1'b0;
         req_value <= VALUE_BITS'($urandom);
         req_radix <= rdc_pkg::RADIX_BITS'($urandom);
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
   endtask

   // Presents one item and returns at the edge where the converter takes it. Push stays
   // high on return, so a following call keeps the channel busy without a gap.
   task automatic offer_item(input logic [VALUE_BITS-1:0] value,
                             input logic [rdc_pkg::RADIX_BITS-1:0] radix);
      req_push  <= 1'b1;
      req_value <= value;
      req_radix <= radix;
      do begin
         @(posedge clock);
      end while (req_full);
   endtask

   // Result side: pop is high most of the time, with stalls of random length in between.
   initial begin
      rsp_pop = 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (!quiet && $urandom_range(0, 7) == 0) begin
            rsp_pop <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end else begin
            rsp_pop <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // Every digit taken from the converter is checked against the oldest one still owed.
   // Values are sampled at the edge, before any of this edge's updates take effect.
   always @(posedge clock) begin
      rdc_pkg::rsp_type want;
      if (!reset) begin
         cycle_count <= cycle_count + 1;
         if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d digits still owed",
                     cycle_count, pending_digits.size());
            $display("Test completed with failures");
            $finish;
         end else if (rsp_pop && !rsp_empty) begin
            if (pending_digits.size() == 0) begin
               report_mismatch("unexpected digit_char", rsp_digit_char, 0);
            end else begin
               want = pending_digits.pop_front();
               if (rsp_digit_char !== want.digit_char) begin
                  report_mismatch("digit_char", rsp_digit_char, want.digit_char);
               end
               if (rsp_last !== want.last) begin
                  report_mismatch("last", rsp_last, want.last);
               end
               if (rsp_error !== want.error) begin
                  report_mismatch("error", rsp_error, want.error);
               end
            end
         end
      end
   end

   initial begin
      logic [VALUE_BITS-1:0]          value;
      logic [rdc_pkg::RADIX_BITS-1:0] radix;
      mismatch_count = 0;
      cycle_count    = 0;
      quiet          = 1'b0;
      reset          = 1'b1;
      req_push       = 1'b0;
      req_value      = '0;
      req_radix      = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed part: each row is offered in order, with the usual random gaps.
      foreach (directed_rows[n]) begin
         sender_pause();
         offer_item(directed_rows[n].value, directed_rows[n].radix);
         case (directed_rows[n].kind)
            ROW_DIGITS: begin
               queue_typed_digits(directed_rows[n].digits);
            end
            ROW_BAD_RADIX: begin
               pending_digits.push_back('{digit_char: rdc_pkg::ERROR_CHAR,
                                          last: 1'b1, error: 1'b1});
            end
            default: begin
               predict_digits(directed_rows[n].value, directed_rows[n].radix);
            end
         endcase
      end

      // Random part. Its last stretch runs back to back with pop held high.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n >= RANDOM_ITEMS - QUIET_ITEMS) begin
            quiet = 1'b1;
         end
         radix = random_radix();
         value = random_value(radix);
         sender_pause();
         offer_item(value, radix);
         predict_digits(value, radix);
      end
      req_push <= 1'b0;

      // Wait for the owed digits, then give any stray results time to show up.
      while (pending_digits.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
